// ===== rtl/core/flpnl_pkg.sv =====
// Package with the command and status types shared by the lot matcher's modules.
package flpnl_pkg;

   // Widths of the item fields at the ports.
   localparam int unsigned SYMBOL_W = 6;
   localparam int unsigned PRICE_W  = 32;
   localparam int unsigned QTY_W    = 24;
   localparam int unsigned TIME_W   = 48;
   localparam int unsigned PNL_W    = 63;

   // Largest symbol count that the 6-bit symbol field can reach.
   localparam int unsigned SYMBOL_SPAN = 64;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic decide;
      logic match;
      logic accum;
      logic open_lot;
      logic write_back;
      logic emit_close;
      logic emit_ovf;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_range;
      logic closing;
      logic qty_zero;
      logic full;
      logic rem_zero;
      logic lots_left;
      logic was_closing;
   } sts_type;

endpackage

// ===== rtl/core/flpnl_ctrl.sv =====
// Controller state machine of the lot matcher.
module flpnl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  flpnl_pkg::sts_type sts,
   output flpnl_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECIDE = 6'b000010,
      ST_MATCH  = 6'b000100,
      ST_ACCUM  = 6'b001000,
      ST_OPEN   = 6'b010000,
      ST_WB     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            priority if (!sts.in_range) begin
               state_in = ST_IDLE;
            end else if (sts.closing) begin
               state_in = ST_MATCH;
            end else if (sts.qty_zero) begin
               state_in = ST_IDLE;
            end else if (sts.full) begin
               cmd.emit_ovf = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_OPEN;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            priority if (sts.rem_zero) begin
               state_in = ST_WB;
            end else if (sts.lots_left) begin
               state_in = ST_MATCH;
            end else begin
               state_in = ST_OPEN;
            end
         end
         ST_OPEN: begin
            cmd.open_lot = 1'b1;
            state_in     = ST_WB;
         end
         ST_WB: begin
            cmd.write_back = 1'b1;
            cmd.emit_close = sts.was_closing;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== rtl/core/flpnl_dp.sv =====
// Datapath of the lot matcher: symbol table, lot store, multiplier and accumulator.
module flpnl_dp #(
   parameter int unsigned NUM_SYMBOLS     = 64,
   parameter int unsigned LOTS_PER_SYMBOL = 16,
   parameter int unsigned PRICE_BITS      = 32,
   parameter int unsigned QTY_BITS        = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  flpnl_pkg::cmd_type                   cmd,
   output flpnl_pkg::sts_type                   sts,
   input  logic                                 lifo_mode,
   input  logic [flpnl_pkg::SYMBOL_W-1:0]       req_symbol_index,
   input  logic                                 req_sell_side,
   input  logic [flpnl_pkg::PRICE_W-1:0]        req_price_ticks,
   input  logic [flpnl_pkg::QTY_W-1:0]          req_trade_quantity,
   input  logic [flpnl_pkg::TIME_W-1:0]         req_trade_time,
   output logic                                 rsp_valid,
   output logic [flpnl_pkg::TIME_W-1:0]         rsp_result_time,
   output logic [flpnl_pkg::SYMBOL_W-1:0]       rsp_result_symbol,
   output logic signed [flpnl_pkg::PNL_W-1:0]   rsp_realized_pnl,
   output logic                                 rsp_lots_overflow
);

   // Only symbols that the 6-bit field can address need storage.
   localparam int unsigned NSE   = (NUM_SYMBOLS < flpnl_pkg::SYMBOL_SPAN) ?
                                   NUM_SYMBOLS : flpnl_pkg::SYMBOL_SPAN;
   localparam int unsigned SW    = (NSE > 1) ? $clog2(NSE) : 1;
   localparam int unsigned HW    = (LOTS_PER_SYMBOL > 1) ? $clog2(LOTS_PER_SYMBOL) : 1;
   localparam int unsigned CW    = $clog2(LOTS_PER_SYMBOL + 1);
   localparam int unsigned DEPTH = NSE * LOTS_PER_SYMBOL;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned PW    = (PRICE_BITS < flpnl_pkg::PRICE_W) ?
                                   PRICE_BITS : flpnl_pkg::PRICE_W;
   localparam int unsigned QW    = (QTY_BITS < flpnl_pkg::QTY_W) ?
                                   QTY_BITS : flpnl_pkg::QTY_W;
   // The sum of matched quantities never exceeds one trade, so this cannot overflow.
   localparam int unsigned ACW   = PW + QW + 2;
   localparam int unsigned EW    = 1 + HW + CW;

   // Storage.
   logic [EW-1:0] sym_mem [NSE];
   logic [NSE-1:0] sym_vld_ff;
   logic [PW-1:0] price_mem [DEPTH];
   logic [QW-1:0] qty_mem [DEPTH];

   // Item registers.
   logic [flpnl_pkg::SYMBOL_W-1:0] sym_ff;
   logic                           sell_ff;
   logic [PW-1:0]                  price_ff;
   logic [QW-1:0]                  rem_ff, rem_in;
   logic [flpnl_pkg::TIME_W-1:0]   time_ff;
   logic                           range_ff;
   logic [EW-1:0]                  sym_rd_ff;
   logic                           sym_rd_vld_ff;

   // Working symbol state.
   logic          short_ff;
   logic [HW-1:0] head_ff;
   logic [CW-1:0] count_ff;
   logic          closing_ff;

   // Lot read data and arithmetic.
   logic [PW-1:0]           lot_price_ff;
   logic [QW-1:0]           lot_qty_ff;
   logic [PW+QW-1:0]        prod_ff;
   logic                    neg_ff;
   logic signed [ACW-1:0]   acc_ff;

   // Output registers.
   logic                               rsp_valid_ff;
   logic [flpnl_pkg::TIME_W-1:0]       rsp_time_ff;
   logic [flpnl_pkg::SYMBOL_W-1:0]     rsp_symbol_ff;
   logic signed [flpnl_pkg::PNL_W-1:0] rsp_pnl_ff;
   logic                               rsp_ovf_ff;

   logic          req_in_range;
   logic [SW-1:0] req_idx, sym_idx;
   logic          ld_short;
   logic [HW-1:0] ld_head;
   logic [CW-1:0] ld_count;
   logic [HW-1:0] rd_pos, head_inc, head_dec, open_pos;
   logic [HW:0]   pos_sum;
   logic [AW-1:0] base_addr, rd_addr, cur_addr, open_addr;
   logic [QW-1:0] take;
   logic          take_all;
   logic [PW-1:0] sellp, buyp, mag;
   logic          neg;
   logic signed [ACW-1:0] term;

   assign req_in_range = (32'(req_symbol_index) < NUM_SYMBOLS);
   assign req_idx      = req_in_range ? SW'(req_symbol_index) : '0;
   assign sym_idx      = SW'(sym_ff);

   // An entry never written reads as the reset state: empty, long, head zero.
   assign ld_short = sym_rd_vld_ff ? sym_rd_ff[EW-1] : 1'b0;
   assign ld_head  = sym_rd_vld_ff ? sym_rd_ff[CW +: HW] : '0;
   assign ld_count = sym_rd_vld_ff ? sym_rd_ff[CW-1:0] : '0;

   assign base_addr = AW'(32'(sym_idx) * LOTS_PER_SYMBOL);
   assign rd_pos    = cmd.decide ? ld_head : head_ff;
   assign rd_addr   = base_addr + AW'(rd_pos);
   assign cur_addr  = base_addr + AW'(head_ff);

   assign head_inc = (32'(head_ff) == LOTS_PER_SYMBOL - 1) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? HW'(LOTS_PER_SYMBOL - 1) : head_ff - 1'b1;
   assign pos_sum  = (HW + 1)'(head_ff) + (HW + 1)'(count_ff);
   always_comb begin
      if (lifo_mode) begin
         open_pos = head_dec;
      end else if (32'(pos_sum) >= LOTS_PER_SYMBOL) begin
         open_pos = HW'(32'(pos_sum) - LOTS_PER_SYMBOL);
      end else begin
         open_pos = HW'(pos_sum);
      end
   end
   assign open_addr = base_addr + AW'(open_pos);

   assign take     = (rem_ff < lot_qty_ff) ? rem_ff : lot_qty_ff;
   assign take_all = (take == lot_qty_ff);
   assign sellp    = sell_ff ? price_ff : lot_price_ff;
   assign buyp     = sell_ff ? lot_price_ff : price_ff;
   assign neg      = (sellp < buyp);
   assign mag      = neg ? (buyp - sellp) : (sellp - buyp);
   assign rem_in   = rem_ff - take;
   assign term     = neg_ff ? -$signed(ACW'(prod_ff)) : $signed(ACW'(prod_ff));

   // Status.
   assign sts.in_range    = range_ff;
   assign sts.closing     = (ld_count != '0) && (ld_short != sell_ff);
   assign sts.qty_zero    = (rem_ff == '0);
   assign sts.full        = (32'(ld_count) >= LOTS_PER_SYMBOL);
   assign sts.rem_zero    = (rem_ff == '0);
   assign sts.lots_left   = (count_ff != '0);
   assign sts.was_closing = closing_ff;

   // Symbol table memory with per-entry valid bits.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sym_rd_ff <= sym_mem[req_idx];
      end
      if (cmd.write_back) begin
         sym_mem[sym_idx] <= {short_ff, head_ff, count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_vld_ff    <= '0;
         sym_rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            sym_rd_vld_ff <= sym_vld_ff[req_idx];
         end
         if (cmd.write_back) begin
            sym_vld_ff[sym_idx] <= 1'b1;
         end
      end
   end

   // Lot store memories.
   always_ff @(posedge clock) begin
      if (cmd.decide || cmd.accum) begin
         lot_price_ff <= price_mem[rd_addr];
         lot_qty_ff   <= qty_mem[rd_addr];
      end
      if (cmd.open_lot) begin
         price_mem[open_addr] <= price_ff;
         qty_mem[open_addr]   <= rem_ff;
      end else if (cmd.match && !take_all) begin
         qty_mem[cur_addr] <= lot_qty_ff - take;
      end
   end

   // Item and working registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sym_ff   <= req_symbol_index;
         sell_ff  <= req_sell_side;
         price_ff <= PW'(req_price_ticks);
         rem_ff   <= QW'(req_trade_quantity);
         time_ff  <= req_trade_time;
         range_ff <= req_in_range;
      end
      if (cmd.decide) begin
         short_ff   <= ld_short;
         head_ff    <= ld_head;
         count_ff   <= ld_count;
         closing_ff <= sts.closing;
         acc_ff     <= '0;
      end
      if (cmd.match) begin
         prod_ff <= mag * take;
         neg_ff  <= neg;
         rem_ff  <= rem_in;
         if (take_all) begin
            head_ff  <= head_inc;
            count_ff <= count_ff - 1'b1;
         end
      end
      if (cmd.accum) begin
         acc_ff <= acc_ff + term;
      end
      if (cmd.open_lot) begin
         short_ff <= sell_ff;
         count_ff <= count_ff + 1'b1;
         if (lifo_mode) begin
            head_ff <= head_dec;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_close || cmd.emit_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_close || cmd.emit_ovf) begin
         rsp_time_ff   <= time_ff;
         rsp_symbol_ff <= sym_ff;
         rsp_ovf_ff    <= cmd.emit_ovf;
         rsp_pnl_ff    <= cmd.emit_ovf ? '0 : flpnl_pkg::PNL_W'(acc_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_time   = rsp_time_ff;
   assign rsp_result_symbol = rsp_symbol_ff;
   assign rsp_realized_pnl  = rsp_pnl_ff;
   assign rsp_lots_overflow = rsp_ovf_ff;

endmodule

// ===== rtl/core/fifo_lifo_lot_matching_pnl_top.sv =====
// Top level of the FIFO/LIFO lot matcher that reports realized PnL per closing trade.
//
// A trade item is taken at a rising edge with start high and busy low. Each symbol
// keeps a ring of open lots; a trade against them closes lots from the head and
// gives one result, any remainder opens a lot. An opening trade on a full symbol
// gives a result with lots_overflow set and PnL zero; other opening trades give none.
// Results appear on the rsp_ ports for one cycle, marked by rsp_valid; the
// receiver must take them, it cannot stall the block.
// Busy stays high through decide, match and accumulate per matched lot, open if a lot
// is opened, write-back; ignored and overflowing trades stop at decide. The result
// shows in the first cycle with busy low. Each matched lot costs one lot store read
// and one multiply-accumulate pass through the shared multiplier. csr_lifo_mode
// selects LIFO (1) or FIFO (0) and is to be written only while the block is idle;
// the block does not enforce this. Reset empties every symbol through its valid bit,
// selects FIFO and drops any item in flight; the lot store itself is not cleared.
module fifo_lifo_lot_matching_pnl_top #(
   parameter int unsigned NUM_SYMBOLS     = 64,
   parameter int unsigned LOTS_PER_SYMBOL = 16,
   parameter int unsigned PRICE_BITS      = 32,
   parameter int unsigned QTY_BITS        = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [flpnl_pkg::SYMBOL_W-1:0]     req_symbol_index,
   input  logic                               req_sell_side,
   input  logic [flpnl_pkg::PRICE_W-1:0]      req_price_ticks,
   input  logic [flpnl_pkg::QTY_W-1:0]        req_trade_quantity,
   input  logic [flpnl_pkg::TIME_W-1:0]       req_trade_time,
   input  logic                               csr_write_enable,
   input  logic                               csr_lifo_mode,
   output logic                               rsp_valid,
   output logic [flpnl_pkg::TIME_W-1:0]       rsp_result_time,
   output logic [flpnl_pkg::SYMBOL_W-1:0]     rsp_result_symbol,
   output logic signed [flpnl_pkg::PNL_W-1:0] rsp_realized_pnl,
   output logic                               rsp_lots_overflow
);

   flpnl_pkg::cmd_type cmd;
   flpnl_pkg::sts_type sts;
   logic lifo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lifo_ff <= 1'b0;
      end else if (csr_write_enable) begin
         lifo_ff <= csr_lifo_mode;
      end
   end

   flpnl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   flpnl_dp #(
      .NUM_SYMBOLS     (NUM_SYMBOLS),
      .LOTS_PER_SYMBOL (LOTS_PER_SYMBOL),
      .PRICE_BITS      (PRICE_BITS),
      .QTY_BITS        (QTY_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .lifo_mode          (lifo_ff),
      .req_symbol_index   (req_symbol_index),
      .req_sell_side      (req_sell_side),
      .req_price_ticks    (req_price_ticks),
      .req_trade_quantity (req_trade_quantity),
      .req_trade_time     (req_trade_time),
      .rsp_valid          (rsp_valid),
      .rsp_result_time    (rsp_result_time),
      .rsp_result_symbol  (rsp_result_symbol),
      .rsp_realized_pnl   (rsp_realized_pnl),
      .rsp_lots_overflow  (rsp_lots_overflow)
   );

endmodule

// ===== rtl/core/flpnl_checker.sv =====
// Port-level checker for the lot matcher and its bind to the top level.
module flpnl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic signed [flpnl_pkg::PNL_W-1:0] rsp_realized_pnl,
   input logic                               rsp_lots_overflow
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while an item is in work");

   a_result_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_lots_overflow) |-> (rsp_realized_pnl == '0))
      else $error("overflow result with nonzero PnL");

endmodule

bind fifo_lifo_lot_matching_pnl_top flpnl_checker u_flpnl_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_realized_pnl  (rsp_realized_pnl),
   .rsp_lots_overflow (rsp_lots_overflow)
);

// ===== sim/tb.sv =====
// Testbench for the FIFO/LIFO lot matcher: directed trades, then random trades checked by a predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned S_W        = flpnl_pkg::SYMBOL_W;
   localparam int unsigned P_W        = flpnl_pkg::PRICE_W;
   localparam int unsigned Q_W        = flpnl_pkg::QTY_W;
   localparam int unsigned T_W        = flpnl_pkg::TIME_W;
   localparam int unsigned R_W        = flpnl_pkg::PNL_W;
   localparam int unsigned LOTS       = 16;
   localparam int unsigned SYMS       = 64;
   localparam int          SETTLE     = 60;
   localparam int          RAND_PER   = 365;
   localparam int          ROW_DEPTH  = 64;
   localparam int          PEND_DEPTH = 8;

   typedef struct {
      logic [S_W-1:0] sym;
      logic           sell;
      logic [P_W-1:0] price;
      logic [Q_W-1:0] qty;
      logic [T_W-1:0] stamp;
   } trade_type;

   typedef struct {
      logic [T_W-1:0] stamp;
      logic [S_W-1:0] sym;
      logic [R_W-1:0] pnl;
      logic           ovf;
   } pnl_result_type;

   typedef struct {
      trade_type      tr;
      bit             typed;
      logic [R_W-1:0] pnl;
      logic           ovf;
   } row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [S_W-1:0]      req_symbol_index = '0;
   logic                req_sell_side = 1'b0;
   logic [P_W-1:0]      req_price_ticks = '0;
   logic [Q_W-1:0]      req_trade_quantity = '0;
   logic [T_W-1:0]      req_trade_time = '0;
   logic                csr_write_enable = 1'b0;
   logic                csr_lifo_mode = 1'b0;
   logic                rsp_valid;
   logic [T_W-1:0]      rsp_result_time;
   logic [S_W-1:0]      rsp_result_symbol;
   logic signed [R_W-1:0] rsp_realized_pnl;
   logic                rsp_lots_overflow;

   fifo_lifo_lot_matching_pnl_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_symbol_index(req_symbol_index), .req_sell_side(req_sell_side),
      .req_price_ticks(req_price_ticks), .req_trade_quantity(req_trade_quantity),
      .req_trade_time(req_trade_time),
      .csr_write_enable(csr_write_enable), .csr_lifo_mode(csr_lifo_mode),
      .rsp_valid(rsp_valid), .rsp_result_time(rsp_result_time),
      .rsp_result_symbol(rsp_result_symbol), .rsp_realized_pnl(rsp_realized_pnl),
      .rsp_lots_overflow(rsp_lots_overflow)
   );

   // Book model: per-symbol lot rings and the accounting mode.
   bit             book_lifo;
   logic [P_W-1:0] book_price [SYMS*LOTS];
   logic [Q_W-1:0] book_qty   [SYMS*LOTS];
   bit             book_short [SYMS];
   logic [3:0]     book_head  [SYMS];
   int unsigned    book_count [SYMS];

   pnl_result_type pending_pnl [PEND_DEPTH];
   int             pend_wr = 0;
   int             pend_rd = 0;
   int             pend_count = 0;
   row_type        rows [ROW_DEPTH];
   int             row_count = 0;
   int             failures = 0;
   int             sender_idle_pct = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("fifo_lifo_lot_matching_pnl_top: mismatch");
      $finish;
   end

   function automatic void pend_put(pnl_result_type r);
      pending_pnl[pend_wr] = r;
      pend_wr = (pend_wr + 1) % PEND_DEPTH;
      pend_count++;
   endfunction

   function automatic pnl_result_type pend_take();
      pnl_result_type r;
      r = pending_pnl[pend_rd];
      pend_rd = (pend_rd + 1) % PEND_DEPTH;
      pend_count--;
      return r;
   endfunction

   function automatic void book_clear();
      book_lifo = 1'b0;
      for (int i = 0; i < SYMS; i++) begin
         book_short[i] = 1'b0;
         book_head[i]  = '0;
         book_count[i] = 0;
      end
   endfunction

   function automatic void book_open(int s, logic [P_W-1:0] p, logic [Q_W-1:0] q);
      logic [3:0] pos;
      if (book_lifo) begin
         book_head[s] = book_head[s] - 4'd1;
         pos = book_head[s];
      end else begin
         pos = book_head[s] + 4'(book_count[s]);
      end
      book_price[s*LOTS + pos] = p;
      book_qty[s*LOTS + pos]   = q;
      book_count[s]++;
   endfunction

   // Applies one trade to the book; returns 1 when the trade yields a result.
   function automatic bit book_trade(trade_type t, output pnl_result_type r);
      int s;
      logic [Q_W-1:0] rem;
      logic [Q_W-1:0] lq;
      logic [Q_W-1:0] take;
      longint diff;
      logic signed [127:0] acc;
      int slot;
      s = int'(t.sym);
      rem = t.qty;
      r.stamp = t.stamp;
      r.sym   = t.sym;
      r.pnl   = '0;
      r.ovf   = 1'b0;
      if (book_count[s] > 0 && book_short[s] != t.sell) begin
         acc = '0;
         while (rem > 0 && book_count[s] > 0) begin
            slot = s*LOTS + book_head[s];
            lq = book_qty[slot];
            take = (rem < lq) ? rem : lq;
            if (t.sell) diff = longint'(t.price) - longint'(book_price[slot]);
            else        diff = longint'(book_price[slot]) - longint'(t.price);
            acc = acc + diff * longint'(take);
            if (take == lq) begin
               book_head[s] = book_head[s] + 4'd1;
               book_count[s]--;
            end else begin
               book_qty[slot] = lq - take;
            end
            rem = rem - take;
         end
         if (rem > 0) begin
            book_short[s] = t.sell;
            book_open(s, t.price, rem);
         end
         if (acc > 128'sh3FFF_FFFF_FFFF_FFFF)       r.pnl = 63'h3FFF_FFFF_FFFF_FFFF;
         else if (acc < -128'sh4000_0000_0000_0000) r.pnl = 63'h4000_0000_0000_0000;
         else                                       r.pnl = acc[R_W-1:0];
         return 1'b1;
      end
      if (rem == 0) return 1'b0;
      if (book_count[s] >= LOTS) begin
         r.ovf = 1'b1;
         return 1'b1;
      end
      book_short[s] = t.sell;
      book_open(s, t.price, rem);
      return 1'b0;
   endfunction

   function automatic trade_type make_trade(int unsigned s, bit sell, longint unsigned p,
                                            longint unsigned q);
      trade_type t;
      t.sym   = S_W'(s);
      t.sell  = sell;
      t.price = P_W'(p);
      t.qty   = Q_W'(q);
      t.stamp = T_W'({$urandom(), $urandom()});
      return t;
   endfunction

   function automatic void add_row(trade_type t, bit typed = 0, logic [R_W-1:0] pnl = '0,
                                   logic ovf = 1'b0);
      row_type r;
      r.tr = t; r.typed = typed; r.pnl = pnl; r.ovf = ovf;
      rows[row_count] = r;
      row_count++;
   endfunction

   // Mostly trades on a few symbols near one price so lots build up and get closed.
   function automatic trade_type random_trade();
      trade_type t;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      t = make_trade($urandom_range(0, 5), 1'($urandom_range(0, 1)),
                     1000 + $urandom_range(0, 200), $urandom_range(1, 40));
      if (pick < 5)       t.qty   = Q_W'($urandom());
      else if (pick < 7)  t.qty   = '0;
      else if (pick < 12) t.price = $urandom();
      else if (pick < 20) begin
         t.sym = S_W'($urandom()); t.price = $urandom(); t.qty = Q_W'($urandom());
      end
      return t;
   endfunction

   // Presents one item; returns at the edge where it is taken.
   task automatic send(trade_type t);
      pnl_result_type r;
      start              <= 1'b1;
      req_symbol_index   <= t.sym;
      req_sell_side      <= t.sell;
      req_price_ticks    <= t.price;
      req_trade_quantity <= t.qty;
      req_trade_time     <= t.stamp;
      do @(posedge clock); while (busy);
      if (book_trade(t, r)) pend_put(r);
   endtask

   task automatic send_row(row_type rw);
      pnl_result_type r;
      start              <= 1'b1;
      req_symbol_index   <= rw.tr.sym;
      req_sell_side      <= rw.tr.sell;
      req_price_ticks    <= rw.tr.price;
      req_trade_quantity <= rw.tr.qty;
      req_trade_time     <= rw.tr.stamp;
      do @(posedge clock); while (busy);
      if (book_trade(rw.tr, r) || rw.typed) begin
         if (rw.typed) begin
            r.pnl = rw.pnl;
            r.ovf = rw.ovf;
         end
         pend_put(r);
      end
   endtask

   task automatic maybe_idle();
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pend_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_mode(bit lifo);
      drain();
      csr_write_enable <= 1'b1;
      csr_lifo_mode    <= lifo;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      book_lifo = lifo;
   endtask

   always @(posedge clock) begin
      pnl_result_type e;
      if (!reset && rsp_valid) begin
         if (pend_count == 0) begin
            $error("result with no item pending");
            failures++;
         end else begin
            e = pend_take();
            if (rsp_result_time !== e.stamp) begin
               $error("result_time exp %h got %h", e.stamp, rsp_result_time);
               failures++;
            end
            if (rsp_result_symbol !== e.sym) begin
               $error("result_symbol exp %0d got %0d", e.sym, rsp_result_symbol);
               failures++;
            end
            if (rsp_realized_pnl !== e.pnl) begin
               $error("realized_pnl exp %0d got %0d", $signed(e.pnl), rsp_realized_pnl);
               failures++;
            end
            if (rsp_lots_overflow !== e.ovf) begin
               $error("lots_overflow exp %b got %b", e.ovf, rsp_lots_overflow);
               failures++;
            end
         end
      end
   end

   initial begin
      book_clear();
      // Open then close a lot in two parts, profit then loss.
      add_row(make_trade(0, 0, 100, 10));
      add_row(make_trade(0, 1, 150, 4), 1, 63'd200, 1'b0);
      add_row(make_trade(0, 1, 0, 6), 1, -63'sd600, 1'b0);
      // Zero quantity on an empty symbol is ignored; against open lots it gives PnL 0.
      add_row(make_trade(1, 0, 7, 0));
      add_row(make_trade(2, 0, 5, 1));
      add_row(make_trade(2, 1, 9, 0), 1, 63'd0, 1'b0);
      add_row(make_trade(2, 1, 9, 3));
      add_row(make_trade(2, 0, 2, 5));
      // Price and quantity extremes.
      add_row(make_trade(63, 0, 0, 24'hFF_FFFF));
      add_row(make_trade(63, 1, 32'hFFFF_FFFF, 24'hFF_FFFF));
      add_row(make_trade(62, 1, 32'hFFFF_FFFF, 24'hFF_FFFF));
      add_row(make_trade(62, 0, 0, 24'hFF_FFFF));
      // Fill one symbol, then one more opening trade overflows.
      for (int i = 0; i < LOTS; i++) add_row(make_trade(5, 0, 10 + i, 1));
      add_row(make_trade(5, 0, 99, 1), 1, 63'd0, 1'b1);
      add_row(make_trade(5, 1, 50, 20));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < row_count; i++) send_row(rows[i]);

      for (int ph = 0; ph < 4; ph++) begin
         set_mode(ph % 2 == 1);
         sender_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 79 : 0;
         for (int n = 0; n < RAND_PER; n++) begin
            send(random_trade());
            if (ph == 1 && n == RAND_PER/2) begin
               drain();
            end else begin
               maybe_idle();
            end
         end
      end
      drain();
      if (failures == 0) $display("fifo_lifo_lot_matching_pnl_top: match");
      else               $display("fifo_lifo_lot_matching_pnl_top: mismatch");
      $finish;
   end
endmodule
